FILE: hdl/sfcc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfcc_pkg: shared types, constants and functions
// CRC-8 byte step, scaling constants and the frame item passed between the
// frame assembler and the scaling stage.
// ---------------------------------------------------------------------------
package sfcc_pkg;

	localparam int BYTE_W   = 8;
	localparam int WORD_W   = 16;
	localparam int TEMP_W   = 15;
	localparam int HUM_W    = 14;
	localparam int STATUS_W = 2;
	localparam int PROD_W   = 32;

	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

	localparam logic [WORD_W-1:0] TEMP_SCALE  = 16'd17500;
	localparam logic [WORD_W-1:0] HUM_SCALE   = 16'd10000;
	localparam logic signed [WORD_W-1:0] TEMP_OFFSET = 16'sd4500;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'b00;
	localparam int STATUS_TEMP_BAD = 0;
	localparam int STATUS_HUM_BAD  = 1;

	typedef struct packed {
		logic [WORD_W-1:0]   raw_temperature;
		logic [WORD_W-1:0]   raw_humidity;
		logic [STATUS_W-1:0] status;
	} frame_item_t;

	// One byte of CRC-8, MSB first.
	function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Floor of x / 65535 for any 32-bit x whose quotient fits in 16 bits, using 65536 = 65535 + 1.
	function automatic logic [WORD_W-1:0] div_65535(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] y;
		logic [PROD_W:0] s;
		y = {1'b0, x} + {{PROD_W{1'b0}}, 1'b1};
		s = y + {{WORD_W{1'b0}}, y[PROD_W:WORD_W]};
		return s[PROD_W-1:WORD_W];
	endfunction

endpackage
`default_nettype wire

FILE: hdl/sfcc_frame.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfcc_frame: frame byte counter and CRC check
// Tracks the byte position, builds the two words, checks both CRC bytes and
// hands a finished frame to the scaling stage through the stage 1 register.
// ---------------------------------------------------------------------------
module sfcc_frame (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [sfcc_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                      frame_start,
	output logic                           item_valid_s1,
	input  wire logic                      item_ready_s1,
	output sfcc_pkg::frame_item_t          item_s1
);
	import sfcc_pkg::*;

	localparam logic [2:0] POS_T_MSB = 3'd0;
	localparam logic [2:0] POS_T_LSB = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_MSB = 3'd3;
	localparam logic [2:0] POS_H_LSB = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	logic [2:0]        pos_q;
	logic [BYTE_W-1:0] crc_q;
	logic [WORD_W-1:0] t_word_q;
	logic [WORD_W-1:0] h_word_q;
	logic              t_ok_q;

	logic [2:0] pos;
	logic       accept;
	logic       last_byte;
	logic       hum_ok;

	assign in_ready  = !item_valid_s1 || item_ready_s1;
	assign accept    = in_valid && in_ready;
	assign pos       = frame_start ? POS_T_MSB : pos_q;
	// Positions above the humidity CRC cannot occur; they end a frame like it.
	assign last_byte = (pos != POS_T_MSB) && (pos != POS_T_LSB) && (pos != POS_T_CRC) &&
		(pos != POS_H_MSB) && (pos != POS_H_LSB);
	assign hum_ok    = (crc_q == rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_T_MSB;
			crc_q  <= CRC_INIT;
			t_ok_q <= 1'b0;
		end else if (accept) begin
			case (pos)
				POS_T_MSB: begin
					crc_q <= crc8_feed(CRC_INIT, rx_byte);
					pos_q <= POS_T_LSB;
				end
				POS_T_LSB: begin
					crc_q <= crc8_feed(crc_q, rx_byte);
					pos_q <= POS_T_CRC;
				end
				POS_T_CRC: begin
					t_ok_q <= (crc_q == rx_byte);
					crc_q  <= CRC_INIT;
					pos_q  <= POS_H_MSB;
				end
				POS_H_MSB: begin
					crc_q <= crc8_feed(CRC_INIT, rx_byte);
					pos_q <= POS_H_LSB;
				end
				POS_H_LSB: begin
					crc_q <= crc8_feed(crc_q, rx_byte);
					pos_q <= POS_H_CRC;
				end
				default: begin
					crc_q <= CRC_INIT;
					pos_q <= POS_T_MSB;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (pos)
				POS_T_MSB: t_word_q[WORD_W-1:BYTE_W] <= rx_byte;
				POS_T_LSB: t_word_q[BYTE_W-1:0]      <= rx_byte;
				POS_H_MSB: h_word_q[WORD_W-1:BYTE_W] <= rx_byte;
				POS_H_LSB: h_word_q[BYTE_W-1:0]      <= rx_byte;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			item_valid_s1 <= 1'b1;
		end else if (item_ready_s1) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			item_s1.raw_temperature         <= t_word_q;
			item_s1.raw_humidity            <= h_word_q;
			item_s1.status[STATUS_TEMP_BAD] <= !t_ok_q;
			item_s1.status[STATUS_HUM_BAD]  <= !hum_ok;
		end
	end

`ifndef NO_ASSERTIONS
	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> pos_q == POS_T_LSB)
		else $error("frame start did not restart the byte count");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_H_CRC)
		else $error("byte position out of range");
	a_crc_init_at_word: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == POS_T_MSB || pos_q == POS_H_MSB) |-> crc_q == CRC_INIT)
		else $error("running CRC not reset at word boundary");
	a_frame_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> item_valid_s1)
		else $error("finished frame did not reach stage 1");
`endif
endmodule
`default_nettype wire

FILE: hdl/sfcc_scale.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfcc_scale: scaling and hold of the last good values
// Stage 2 registers the two products; the output stage divides by 65535,
// applies the offset and keeps the previous values when a CRC failed.
// ---------------------------------------------------------------------------
module sfcc_scale (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid_s1,
	output logic                               item_ready_s1,
	input  wire sfcc_pkg::frame_item_t         item_s1,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [sfcc_pkg::TEMP_W-1:0] temperature_centi,
	output logic [sfcc_pkg::HUM_W-1:0]         humidity_centi,
	output logic [sfcc_pkg::WORD_W-1:0]        raw_temperature,
	output logic [sfcc_pkg::WORD_W-1:0]        raw_humidity,
	output logic [sfcc_pkg::STATUS_W-1:0]      status
);
	import sfcc_pkg::*;

	logic              valid_s2;
	frame_item_t       item_s2;
	logic [PROD_W-1:0] t_prod_s2;
	logic [PROD_W-1:0] h_prod_s2;

	logic                    adv_s2;
	logic [WORD_W-1:0]       t_quot;
	logic [WORD_W-1:0]       h_quot;
	logic signed [WORD_W-1:0] t_centi;

	assign adv_s2        = !out_valid || out_ready;
	assign item_ready_s1 = !valid_s2 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (item_ready_s1) begin
			valid_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready_s1 && item_valid_s1) begin
			item_s2   <= item_s1;
			t_prod_s2 <= PROD_W'(item_s1.raw_temperature) * PROD_W'(TEMP_SCALE);
			h_prod_s2 <= PROD_W'(item_s1.raw_humidity) * PROD_W'(HUM_SCALE);
		end
	end

	assign t_quot  = div_65535(t_prod_s2);
	assign h_quot  = div_65535(h_prod_s2);
	assign t_centi = $signed(t_quot) - TEMP_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid         <= 1'b0;
			temperature_centi <= '0;
			humidity_centi    <= '0;
		end else if (adv_s2) begin
			out_valid <= valid_s2;
			if (valid_s2 && item_s2.status == STATUS_OK) begin
				temperature_centi <= t_centi[TEMP_W-1:0];
				humidity_centi    <= h_quot[HUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s2) begin
			raw_temperature <= item_s2.raw_temperature;
			raw_humidity    <= item_s2.raw_humidity;
			status          <= item_s2.status;
		end
	end

`ifndef NO_ASSERTIONS
	a_bad_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && valid_s2 && item_s2.status != STATUS_OK |=>
		$stable(temperature_centi) && $stable(humidity_centi))
		else $error("scaled values changed on a failed frame");
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && valid_s2 |=> out_valid)
		else $error("stage 2 item lost");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temperature_centi) &&
		$stable(humidity_centi) && $stable(raw_temperature) && $stable(raw_humidity) &&
		$stable(status))
		else $error("stalled output request changed");
`endif
endmodule
`default_nettype wire

FILE: hdl/sensor_frame_crc_check_scale.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sensor_frame_crc_check_scale: checked temperature/humidity frame decoder
// Receives the six frame bytes one per request and returns the raw words,
// a CRC status and the scaled temperature and humidity.
// ---------------------------------------------------------------------------
// Input channel s_axis: one frame byte per request in tdata, tuser set on
// the first byte of a frame. Without tuser the byte count wraps after six.
// Output channel m_axis: one request per frame, after its sixth byte. The
// scaled values are the last ones whose two CRC bytes matched.
// Throughput: one byte per cycle, sustained while m_axis takes results. A
// result reaches m_axis from the edge that takes the sixth byte through
// the stage 1 frame register, the stage 2 product register, then the
// output register.
// When m_axis stalls, the result is held and the byte count and CRC keep
// running; s_axis drops tready for any byte once stage 1, stage 2 and the
// output register are all full.
// Reset clears the byte count, the CRC to 0xFF, the temperature check flag
// and the held values to zero, and empties every stage.
// ---------------------------------------------------------------------------
module sensor_frame_crc_check_scale (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  wire logic        s_axis_tuser,  // [0] frame_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [14:0] temperature_centi, [28:15] humidity_centi, [44:29] raw_temperature,
	// [60:45] raw_humidity, [62:61] status, [63] zero
	output logic [63:0]      m_axis_tdata
);
	import sfcc_pkg::*;

	logic                    item_valid_s1;
	logic                    item_ready_s1;
	frame_item_t             item_s1;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic [HUM_W-1:0]        humidity_centi;
	logic [WORD_W-1:0]       raw_temperature;
	logic [WORD_W-1:0]       raw_humidity;
	logic [STATUS_W-1:0]     status;

	sfcc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.rx_byte       (s_axis_tdata),
		.frame_start   (s_axis_tuser),
		.item_valid_s1 (item_valid_s1),
		.item_ready_s1 (item_ready_s1),
		.item_s1       (item_s1)
	);

	sfcc_scale u_scale (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid_s1     (item_valid_s1),
		.item_ready_s1     (item_ready_s1),
		.item_s1           (item_s1),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.raw_temperature   (raw_temperature),
		.raw_humidity      (raw_humidity),
		.status            (status)
	);

	assign m_axis_tdata = {1'b0, status, raw_humidity, raw_temperature, humidity_centi,
		temperature_centi};

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: sensor frame CRC check and scaling
// Feeds six-byte temperature/humidity frames on s_axis, first a table of
// hand-picked frames and then random frames, noise and cut-off frames. A
// behavioral decoder predicts each reading, which is compared field by field
// with what m_axis delivers, under changing idle patterns on both sides.
// ---------------------------------------------------------------------------
module testbench;
	import sfcc_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL  = 400;
	localparam int DRAIN_WAIT  = 8;
	localparam int PHASE_ITEMS = 500;
	localparam int MAX_REPORTS = 10;

	localparam logic [STATUS_W-1:0] ST_TEMP_BAD = STATUS_W'(1 << STATUS_TEMP_BAD);
	localparam logic [STATUS_W-1:0] ST_HUM_BAD  = STATUS_W'(1 << STATUS_HUM_BAD);

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic [HUM_W-1:0]         humidity;
		logic [WORD_W-1:0]        raw_temperature;
		logic [WORD_W-1:0]        raw_humidity;
		logic [STATUS_W-1:0]      status;
	} reading_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              start;
		bit                typed;
		int                temperature;
		int                humidity;
		int                raw_temperature;
		int                raw_humidity;
		logic [STATUS_W-1:0] status;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;

	// Decoder state as the block should hold it.
	logic [2:0]               decoder_pos = '0;
	logic [BYTE_W-1:0]        decoder_crc = CRC_INIT;
	logic [WORD_W-1:0]        decoder_temp_word = '0;
	logic [WORD_W-1:0]        decoder_hum_word = '0;
	logic                     decoder_temp_ok = 1'b0;
	logic signed [TEMP_W-1:0] held_temp = '0;
	logic [HUM_W-1:0]         held_hum = '0;

	reading_t  pending_readings[$];
	stim_row_t directed_rows[26];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int items_sent = 0;
	int mismatches = 0;
	int cycle_count = 0;

	sensor_frame_crc_check_scale dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sensor_frame_crc_check_scale verification failed");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		repeat (BYTE_W) begin
			c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] word_crc(input logic [WORD_W-1:0] w);
		return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return WORD_W'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	// Advances the decoder by one byte; a reading comes out on the sixth byte.
	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic st,
		output bit produced, output reading_t r);
		logic [2:0] pos;
		logic       hum_ok;
		logic [STATUS_W-1:0] st_bits;
		pos = st ? 3'd0 : decoder_pos;
		produced = 1'b0;
		r = '0;
		case (pos)
			3'd0: begin
				decoder_temp_word[15:8] = b;
				decoder_crc = crc8_step(CRC_INIT, b);
			end
			3'd1: begin
				decoder_temp_word[7:0] = b;
				decoder_crc = crc8_step(decoder_crc, b);
			end
			3'd2: begin
				decoder_temp_ok = (decoder_crc == b);
				decoder_crc = CRC_INIT;
			end
			3'd3: begin
				decoder_hum_word[15:8] = b;
				decoder_crc = crc8_step(CRC_INIT, b);
			end
			3'd4: begin
				decoder_hum_word[7:0] = b;
				decoder_crc = crc8_step(decoder_crc, b);
			end
			default: begin
				hum_ok = (decoder_crc == b);
				decoder_crc = CRC_INIT;
				st_bits = STATUS_OK;
				if (!decoder_temp_ok) begin
					st_bits = st_bits | ST_TEMP_BAD;
				end
				if (!hum_ok) begin
					st_bits = st_bits | ST_HUM_BAD;
				end
				if (st_bits == STATUS_OK) begin
					held_temp = TEMP_W'((int'(TEMP_SCALE) * int'(decoder_temp_word)) / 65535
						- int'(TEMP_OFFSET));
					held_hum = HUM_W'((int'(HUM_SCALE) * int'(decoder_hum_word)) / 65535);
				end
				r.temperature     = held_temp;
				r.humidity        = held_hum;
				r.raw_temperature = decoder_temp_word;
				r.raw_humidity    = decoder_hum_word;
				r.status          = st_bits;
				produced = 1'b1;
			end
		endcase
		decoder_pos = (pos == 3'd5) ? 3'd0 : pos + 3'd1;
	endtask

	// Offers one byte after a random gap; on acceptance the decoder advances.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic st,
		input bit typed, input reading_t typed_reading);
		bit       produced;
		reading_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= st;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		decode_byte(b, st, produced, r);
		if (produced) begin
			pending_readings.push_back(typed ? typed_reading : r);
		end
	endtask

	task automatic send_frame(input logic [WORD_W-1:0] tw, input logic [WORD_W-1:0] hw,
		input bit temp_bad, input bit hum_bad, input logic st);
		logic [BYTE_W-1:0] ct;
		logic [BYTE_W-1:0] ch;
		ct = word_crc(tw) ^ (temp_bad ? BYTE_W'($urandom_range(1, 255)) : '0);
		ch = word_crc(hw) ^ (hum_bad ? BYTE_W'($urandom_range(1, 255)) : '0);
		send_byte(tw[15:8], st, 1'b0, '0);
		send_byte(tw[7:0], 1'b0, 1'b0, '0);
		send_byte(ct, 1'b0, 1'b0, '0);
		send_byte(hw[15:8], 1'b0, 1'b0, '0);
		send_byte(hw[7:0], 1'b0, 1'b0, '0);
		send_byte(ch, 1'b0, 1'b0, '0);
	endtask

	// The sender pauses until every reading has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] expected,
		input logic [WORD_W-1:0] actual);
		if (expected !== actual) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("mismatch in %s: expected %h, got %h", name, expected, actual);
			end
		end
	endtask

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("reading with none pending: %h", m_axis_tdata);
				end
			end else begin
				want = pending_readings.pop_front();
				check_field("temperature_centi", WORD_W'(unsigned'(want.temperature)),
					WORD_W'(m_axis_tdata[14:0]));
				check_field("humidity_centi", WORD_W'(want.humidity),
					WORD_W'(m_axis_tdata[28:15]));
				check_field("raw_temperature", want.raw_temperature, m_axis_tdata[44:29]);
				check_field("raw_humidity", want.raw_humidity, m_axis_tdata[60:45]);
				check_field("status", WORD_W'(want.status), WORD_W'(m_axis_tdata[62:61]));
			end
		end
	end

	initial begin
		reading_t  typed_reading;
		stim_row_t row;
		logic      st;
		int        pick;
		int        phase;
		int        phase_end;
		int        n;

		// Known frames: all-zero and all-one words, a frame start that drops a
		// partial frame, a wrap without frame start, and each CRC failing alone.
		directed_rows = '{
			'{8'h00, 1'b1, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h81, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h81, 1'b0, 1'b1, -4500, 0, 0, 0, STATUS_OK},
			'{8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hAC, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hAC, 1'b0, 1'b1, 13000, 10000, 16'hFFFF, 16'hFFFF, STATUS_OK},
			'{8'h12, 1'b1, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h34, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hFF, 1'b1, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h00, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h81, 1'b0, 1'b1, 13000, 10000, 16'hFFFF, 16'h0000, ST_TEMP_BAD},
			'{8'hBE, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hEF, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h92, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hBE, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'hEF, 1'b0, 1'b0, 0, 0, 0, 0, STATUS_OK},
			'{8'h93, 1'b0, 1'b1, 13000, 10000, 16'hBEEF, 16'hBEEF, ST_HUM_BAD}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 45;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			typed_reading.temperature     = TEMP_W'(row.temperature);
			typed_reading.humidity        = HUM_W'(row.humidity);
			typed_reading.raw_temperature = WORD_W'(row.raw_temperature);
			typed_reading.raw_humidity    = WORD_W'(row.raw_humidity);
			typed_reading.status          = row.status;
			send_byte(row.data, row.start, row.typed, typed_reading);
		end
		wait_drained();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 45;
				end
				1: begin
					send_idle_pct = 45;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					// Long receiver hold-off while bytes keep coming.
					hold_left = LONG_STALL;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				// A frame without start flag is only well formed on a boundary.
				st = (decoder_pos != 3'd0) ? 1'b1 : logic'($urandom_range(0, 1));
				if (pick < 80) begin
					send_frame(pick_word(), pick_word(), $urandom_range(0, 99) < 15,
						$urandom_range(0, 99) < 15, st);
				end else if (pick < 90) begin
					send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
						1'b0, '0);
				end else begin
					n = $urandom_range(1, 5);
					for (int k = 0; k < n; k++) begin
						send_byte(BYTE_W'($urandom_range(0, 255)), (k == 0) ? st : 1'b0,
							1'b0, '0);
					end
				end
			end
			wait_drained();
		end

		if (mismatches == 0 && pending_readings.size() == 0) begin
			$display("sensor_frame_crc_check_scale verification clean");
		end else begin
			$display("sensor_frame_crc_check_scale verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/sfcc_pkg.sv
hdl/sfcc_frame.sv
hdl/sfcc_scale.sv
hdl/sensor_frame_crc_check_scale.sv
test/testbench.sv
